FILE: hw/rtl/utf8_to_utf16_transcoder_unit_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder assertion macros
// Shared property shapes for the transcoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH

// Same-cycle implication on clk, off while rst_n is low.
`define U8U16_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off while rst_n is low.
`define U8U16_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types, constants and byte classing for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int unsigned MaxUnits = 4;

  localparam logic [15:0] REPL_UNIT    = 16'h003F;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // Numeric values double as the sequence length for the lead kinds.
  typedef enum logic [2:0] {
    KIND_CONT  = 3'd0,
    KIND_ASCII = 3'd1,
    KIND_LEAD2 = 3'd2,
    KIND_LEAD3 = 3'd3,
    KIND_LEAD4 = 3'd4,
    KIND_BAD   = 3'd5
  } byte_kind_t;

  typedef struct packed {
    logic [7:0] lead;
    logic [2:0] seq_len;
    logic [1:0] held_cnt;
    logic [5:0] held0;
    logic [5:0] held1;
  } u8u16_state_t;

  typedef struct packed {
    logic [MaxUnits-1:0][15:0] unit;
    logic [MaxUnits-1:0]       repl;
    logic [2:0]                count;
  } u8u16_burst_t;

  function automatic byte_kind_t classify(input logic [4:0] top);
    byte_kind_t k;
    unique case (top) inside
      [5'd0:5'd15]:  k = KIND_ASCII;
      [5'd16:5'd23]: k = KIND_CONT;
      [5'd24:5'd27]: k = KIND_LEAD2;
      [5'd28:5'd29]: k = KIND_LEAD3;
      5'd30:         k = KIND_LEAD4;
      default:       k = KIND_BAD;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/u8u16_in_if.sv
// ----------------------------------------------------------------------------
// u8u16_in_if
// Byte channel into the transcoder: one UTF-8 byte and its end mark per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

FILE: hw/rtl/u8u16_out_if.sv
// ----------------------------------------------------------------------------
// u8u16_out_if
// Result channel of the transcoder: one UTF-16 code unit per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit;
  logic        is_replacement;
  logic        last_of_run;

  modport source (output valid, output unit, output is_replacement, output last_of_run,
                  input ready);
  modport sink   (input valid, input unit, input is_replacement, input last_of_run,
                  output ready);
endinterface

FILE: hw/rtl/utf8_to_utf16_transcoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// Streaming UTF-8 to UTF-16 transcoder, one byte in, zero to four units out.
// ----------------------------------------------------------------------------
// A byte taken on in_ch is held in the input register; it is then decoded
// against the open sequence and, once the result register is free, its units
// are loaded into the result register, from which out_ch offers the first
// unit. Bytes are taken one per cycle while each yields at most one
// unit and out_ch is ready. A byte that yields k units (a surrogate pair, a
// flush of a broken or truncated sequence) occupies the result register until
// all k units are taken, one unit per cycle while out_ch is ready, and holds
// the next byte in the input register until then. Bytes that only extend an
// open sequence yield no units and move on without waiting for the result register.
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_unit_macros.svh"

module utf8_to_utf16_transcoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch
);

  logic                    in_valid_r;
  logic [7:0]              byte_r;
  logic                    eos_r;
  u8u16_pkg::u8u16_state_t st_r;
  u8u16_pkg::u8u16_state_t st_nxt;
  u8u16_pkg::u8u16_burst_t burst;
  logic                    free;
  logic                    move;
  logic                    load;
  logic                    accept;
  logic                    in_valid_nxt;

  u8u16_decode u_decode (
    .st      (st_r),
    .in_byte (byte_r),
    .eos     (eos_r),
    .st_nxt  (st_nxt),
    .burst   (burst)
  );

  u8u16_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .burst  (burst),
    .free   (free),
    .out_ch (out_ch)
  );

  // a byte with no units moves on regardless of the result register
  assign move        = in_valid_r && ((burst.count == 3'd0) || free);
  assign load        = move && (burst.count != 3'd0);
  assign in_ch.ready = !in_valid_r || move;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (move) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (move) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_ch.in_byte;
      eos_r  <= in_ch.end_of_string;
    end
  end

  `U8U16_ASSERT_IMP(a_seq_len_legal, 1'b1, (st_r.seq_len == 3'd0) || (st_r.seq_len == 3'd2) || (st_r.seq_len == 3'd3) || (st_r.seq_len == 3'd4), "sequence length out of range")
  `U8U16_ASSERT_IMP(a_held_bound, st_r.seq_len != 3'd0, ({1'b0, st_r.held_cnt} + 3'd1) < st_r.seq_len, "held continuation count too large")
  `U8U16_ASSERT_IMP(a_burst_bound, in_valid_r, burst.count <= 3'd4, "burst longer than four units")
  `U8U16_ASSERT_NXT(a_eos_closes, move && eos_r, st_r.seq_len == 3'd0, "sequence left open after end of string")

endmodule

FILE: hw/rtl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// Per-byte decode: next sequence state and the burst of up to four units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8u16_decode (
  input  u8u16_pkg::u8u16_state_t st,
  input  logic [7:0]              in_byte,
  input  logic                    eos,
  output u8u16_pkg::u8u16_state_t st_nxt,
  output u8u16_pkg::u8u16_burst_t burst
);

  u8u16_pkg::byte_kind_t   kind;
  u8u16_pkg::u8u16_state_t st_mid;
  logic [5:0]              pay;
  logic                    is_open;
  logic                    is_cont;
  logic [1:0]              held_cap;
  logic [1:0]              mid_cap;
  logic                    complete;
  logic                    hold;
  logic                    broken;
  logic                    fresh;
  logic [20:0]             cp;
  logic [20:0]             cp_off;
  logic [2:0]              a_cnt;
  logic [2:0]              b_cnt;
  logic [2:0]              c_cnt;
  logic [1:0][15:0]        b_unit;
  logic [1:0]              b_repl;
  logic [2:0]              slot;
  logic [2:0]              rel;

  always_comb begin
    kind     = u8u16_pkg::classify(in_byte[7:3]);
    pay      = in_byte[5:0];
    is_open  = (st.seq_len != 3'd0);
    is_cont  = (kind == u8u16_pkg::KIND_CONT);
    held_cap = (st.held_cnt > 2'd2) ? 2'd2 : st.held_cnt;
    complete = is_open && is_cont && (({1'b0, st.held_cnt} + 3'd2) >= st.seq_len);
    hold     = is_open && is_cont && !complete;
    broken   = is_open && !is_cont;
    fresh    = !is_open || broken;
    a_cnt    = broken ? (3'd1 + {1'b0, held_cap}) : 3'd0;

    // assemble the code point of a finished sequence
    if (st.seq_len == 3'd2) begin
      cp = {10'd0, st.lead[4:0], pay};
    end else if (st.seq_len == 3'd3) begin
      cp = {5'd0, st.lead[3:0], st.held0, pay};
    end else begin
      cp = {st.lead[2:0], st.held0, st.held1, pay};
    end
    cp_off = cp - u8u16_pkg::SUPP_BASE;

    b_cnt  = 3'd0;
    b_unit = '0;
    b_repl = '0;
    st_mid = st;

    if (complete || broken) begin
      st_mid = '0;
    end
    if (hold) begin
      if (st.held_cnt[0]) begin
        st_mid.held1 = pay;
      end else begin
        st_mid.held0 = pay;
      end
      st_mid.held_cnt = st.held_cnt + 2'd1;
    end

    if (complete) begin
      if (cp[20:16] != 5'd0) begin
        b_cnt     = 3'd2;
        b_unit[0] = u8u16_pkg::SURR_HI_BASE + {5'd0, cp_off[20:10]};
        b_unit[1] = u8u16_pkg::SURR_LO_BASE | {6'd0, cp_off[9:0]};
      end else begin
        b_cnt     = 3'd1;
        b_unit[0] = cp[15:0];
      end
    end else if (fresh) begin
      case (kind)
        u8u16_pkg::KIND_ASCII: begin
          b_cnt     = 3'd1;
          b_unit[0] = {8'd0, in_byte};
        end
        u8u16_pkg::KIND_CONT, u8u16_pkg::KIND_BAD: begin
          b_cnt     = 3'd1;
          b_unit[0] = u8u16_pkg::REPL_UNIT;
          b_repl[0] = 1'b1;
        end
        default: begin
          // open a new sequence on a lead byte
          st_mid          = '0;
          st_mid.lead     = in_byte;
          st_mid.seq_len  = kind;
        end
      endcase
    end

    // flush whatever is still open at the end of the string
    mid_cap = (st_mid.held_cnt > 2'd2) ? 2'd2 : st_mid.held_cnt;
    if (eos && (st_mid.seq_len != 3'd0)) begin
      c_cnt  = 3'd1 + {1'b0, mid_cap};
      st_nxt = '0;
    end else begin
      c_cnt  = 3'd0;
      st_nxt = st_mid;
    end

    burst.count = a_cnt + b_cnt + c_cnt;
    for (int i = 0; i < u8u16_pkg::MaxUnits; i++) begin
      slot = 3'(i);
      rel  = slot - a_cnt;
      if ((slot >= a_cnt) && (slot < (a_cnt + b_cnt))) begin
        burst.unit[i] = b_unit[rel[0]];
        burst.repl[i] = b_repl[rel[0]];
      end else begin
        burst.unit[i] = u8u16_pkg::REPL_UNIT;
        burst.repl[i] = 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/u8u16_emit.sv
// ----------------------------------------------------------------------------
// u8u16_emit
// Result register: holds one burst of units and hands them out one per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8u16_emit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  u8u16_pkg::u8u16_burst_t burst,
  output logic                    free,
  u8u16_out_if.source             out_ch
);

  logic [u8u16_pkg::MaxUnits-1:0][15:0] unit_r;
  logic [u8u16_pkg::MaxUnits-1:0]       repl_r;
  logic [2:0]                           cnt_r;
  logic [1:0]                           idx_r;
  logic                                 valid_r;
  logic [1:0]                           idx_nxt;
  logic                                 valid_nxt;
  logic                                 last;
  logic                                 take;

  assign last = ({1'b0, idx_r} == (cnt_r - 3'd1));
  assign take = valid_r && out_ch.ready;
  assign free = !valid_r || (out_ch.ready && last);

  assign out_ch.valid          = valid_r;
  assign out_ch.unit           = unit_r[idx_r];
  assign out_ch.is_replacement = repl_r[idx_r];
  assign out_ch.last_of_run    = last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = 2'd0;
      valid_nxt = 1'b1;
    end else if (take) begin
      // advance within the burst, drop valid after its last unit
      idx_nxt   = idx_r + 2'd1;
      valid_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= burst.unit;
      repl_r <= burst.repl;
      cnt_r  <= burst.count;
    end
  end

endmodule
